@@ rtl/lru_node_cache_tag_manager_defines.svh @@
// assertion macros shared by the rtl
`ifndef LRU_NODE_CACHE_TAG_MANAGER_DEFINES_SVH
`define LRU_NODE_CACHE_TAG_MANAGER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define LNCTM_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define LNCTM_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/lnctm_pkg.sv @@
`default_nettype none

package lnctm_pkg;

    localparam int DEF_SLOTS       = 32;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_STAMP_WIDTH = 32;

    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_NODE_LIMIT = 1'b0;
    localparam logic [15:0] NODE_LIMIT_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_ACCESS      = 3'd0,
        MODE_MARK_DIRTY  = 3'd1,
        MODE_WRITE_BACK  = 3'd2,
        MODE_INVALIDATE  = 3'd3,
        MODE_SYNC        = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STS_HIT         = 3'd0,
        STS_FILLED      = 3'd1,
        STS_FILL_FAILED = 3'd2,
        STS_REJECTED    = 3'd3,
        STS_ABSENT      = 3'd4,
        STS_WRITEBACK   = 3'd5,
        STS_SYNC_DONE   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT,
        ST_WB_VICTIM,
        ST_FILL,
        ST_SYNC_SCAN,
        ST_SYNC_RD,
        ST_SYNC_WB,
        ST_SYNC_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] node_id;
        logic        fill_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] node_out;
        logic [5:0]  valid_count;
        logic [5:0]  dirty_count;
        logic        last;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/lru_node_cache_tag_manager.sv @@
`default_nettype none
// channel | role           | handshake                | payload
// req     | item in        | req_valid / req_stall    | mode, node_id, fill_ok
// rsp     | result out     | rsp_valid / rsp_stall    | status, slot, node_out, counts, last
// apb     | configuration  | psel penable pwrite      | node_limit at byte address 0
//
// one sequencer walks the slots through a single tag/stamp read port and compare unit
// lookup: accept, scan of every slot, 1 or 2 result beats; rejected items skip the scan
// sync: accept, scan, then per dirty slot a read and a writeback beat, then the done beat
// reset clears valid, dirty, counts and the stamp counter at once, no clearing pass
// a stalled rsp holds the sequencer in its result state; req is taken only when idle

module lru_node_cache_tag_manager #(
    parameter int SLOTS       = lnctm_pkg::DEF_SLOTS,
    parameter int ID_WIDTH    = lnctm_pkg::DEF_ID_WIDTH,
    parameter int STAMP_WIDTH = lnctm_pkg::DEF_STAMP_WIDTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_stall,
    input  lnctm_pkg::req_t                   req,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output lnctm_pkg::rsp_t                   rsp,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [lnctm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire [31:0]                        pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lnctm_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS);

    // slot storage
    logic [ID_WIDTH-1:0]    tag_mem   [SLOTS];
    logic [STAMP_WIDTH-1:0] stamp_mem [SLOTS];
    logic [ID_WIDTH-1:0]    tag_q;
    logic [STAMP_WIDTH-1:0] stamp_q;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [SLOTS-1:0]       dirty_reg, dirty_next;
    logic [CNT_W-1:0]       vc_reg, vc_next;
    logic [CNT_W-1:0]       dc_reg, dc_next;
    logic [STAMP_WIDTH-1:0] stamp_cnt_reg;

    // current item
    state_t                 state_reg, state_next;
    logic [2:0]             mode_reg, mode_next;
    logic [ID_WIDTH-1:0]    id_reg, id_next;
    logic                   fill_ok_reg, fill_ok_next;
    logic                   rej_reg, rej_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // scan results
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                   empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]       empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]       min_idx_reg, min_idx_next;
    logic [STAMP_WIDTH-1:0] min_stamp_reg, min_stamp_next;
    logic [ID_WIDTH-1:0]    min_tag_reg, min_tag_next;

    // result buffer
    logic                   ov_reg;
    rsp_t                   rsp_reg;

    logic [15:0]            limit_reg;

    // sequencer outputs
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       eval_idx;
    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W-1:0]       victim_idx;
    logic                   out_free;
    logic                   emit;
    rsp_t                   res;
    logic                   touch_en;
    logic [IDX_W-1:0]       touch_idx;
    logic                   tag_we;
    logic [ID_WIDTH-1:0]    req_id;
    logic                   req_id_ok;
    logic                   req_rej;

    assign out_free   = !ov_reg || !rsp_stall;
    assign victim_idx = empty_found_reg ? empty_idx_reg : min_idx_reg;
    assign cnt_m1     = cnt_reg - 1'b1;
    assign eval_idx   = cnt_m1[IDX_W-1:0];
    assign rd_addr    = (cnt_reg < LAST_CNT) ? cnt_reg[IDX_W-1:0] : '0;

    // id rules checked when the beat is taken
    assign req_id    = ID_WIDTH'(req.node_id);
    assign req_id_ok = (req_id != '0) && (32'(req_id) < 32'(limit_reg));
    assign req_rej   = (((req.mode == MODE_ACCESS) || (req.mode == MODE_WRITE_BACK))
                        && !req_id_ok) || (req.mode > MODE_SYNC);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_NODE_LIMIT) ? {16'b0, limit_reg} : 32'b0;

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        id_next          = id_reg;
        fill_ok_next     = fill_ok_reg;
        rej_next         = rej_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        min_idx_next     = min_idx_reg;
        min_stamp_next   = min_stamp_reg;
        min_tag_next     = min_tag_reg;
        valid_next       = valid_reg;
        dirty_next       = dirty_reg;
        vc_next          = vc_reg;
        dc_next          = dc_reg;
        emit             = 1'b0;
        res              = '0;
        touch_en         = 1'b0;
        touch_idx        = hit_idx_reg;
        tag_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next        = req.mode;
                    id_next          = req_id;
                    fill_ok_next     = req.fill_ok;
                    cnt_next         = '0;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                    rej_next         = req_rej;
                    if (req_rej)
                        state_next = ST_RESULT;
                    else if (req.mode == MODE_SYNC)
                        state_next = ST_SYNC_SCAN;
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // data of slot cnt-1 arrives while slot cnt is read
                if (cnt_reg != '0)
                begin
                    if (valid_reg[eval_idx] && (tag_q == id_reg) && (id_reg != '0)
                        && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = eval_idx;
                    end
                    if (!valid_reg[eval_idx] && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = eval_idx;
                    end
                    if ((eval_idx == '0) || (stamp_q < min_stamp_reg))
                    begin
                        min_idx_next   = eval_idx;
                        min_stamp_next = stamp_q;
                        min_tag_next   = tag_q;
                    end
                end
                if (cnt_reg == LAST_CNT)
                begin
                    if ((mode_reg != MODE_ACCESS) || found_next)
                        state_next = ST_RESULT;
                    else if (!empty_found_next && dirty_reg[min_idx_next])
                        state_next = ST_WB_VICTIM;
                    else
                        state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    res.node_out = 16'(id_reg);
                    res.last     = 1'b1;
                    state_next   = ST_IDLE;
                    rej_next     = 1'b0;
                    if (rej_reg)
                        res.status = STS_REJECTED;
                    else if (!found_reg)
                        res.status = STS_ABSENT;
                    else
                    begin
                        res.slot = 5'(hit_idx_reg);
                        touch_en = 1'b1;
                        case (mode_reg)
                            MODE_MARK_DIRTY:
                            begin
                                res.status = STS_HIT;
                                dirty_next[hit_idx_reg] = 1'b1;
                                if (!dirty_reg[hit_idx_reg])
                                    dc_next = dc_reg + 1'b1;
                            end
                            MODE_WRITE_BACK:
                            begin
                                res.status = STS_WRITEBACK;
                                dirty_next[hit_idx_reg] = 1'b0;
                                if (dirty_reg[hit_idx_reg])
                                    dc_next = dc_reg - 1'b1;
                            end
                            MODE_INVALIDATE:
                            begin
                                // emptied without writeback
                                res.status = STS_HIT;
                                valid_next[hit_idx_reg] = 1'b0;
                                dirty_next[hit_idx_reg] = 1'b0;
                                vc_next = vc_reg - 1'b1;
                                if (dirty_reg[hit_idx_reg])
                                    dc_next = dc_reg - 1'b1;
                            end
                            default:
                            begin
                                res.status = STS_HIT;
                            end
                        endcase
                    end
                end
            end

            ST_WB_VICTIM:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    res.status   = STS_WRITEBACK;
                    res.slot     = 5'(min_idx_reg);
                    res.node_out = 16'(min_tag_reg);
                    touch_en     = 1'b1;
                    touch_idx    = min_idx_reg;
                    dirty_next[min_idx_reg] = 1'b0;
                    dc_next      = dc_reg - 1'b1;
                    state_next   = ST_FILL;
                end
            end

            ST_FILL:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    res.slot     = 5'(victim_idx);
                    res.node_out = 16'(id_reg);
                    res.last     = 1'b1;
                    dirty_next[victim_idx] = 1'b0;
                    if (dirty_reg[victim_idx])
                        dc_next = dc_reg - 1'b1;
                    if (fill_ok_reg)
                    begin
                        res.status = STS_FILLED;
                        tag_we     = 1'b1;
                        touch_en   = 1'b1;
                        touch_idx  = victim_idx;
                        valid_next[victim_idx] = 1'b1;
                        if (!valid_reg[victim_idx])
                            vc_next = vc_reg + 1'b1;
                    end
                    else
                    begin
                        // payload already overwritten, slot left empty
                        res.status = STS_FILL_FAILED;
                        valid_next[victim_idx] = 1'b0;
                        if (valid_reg[victim_idx])
                            vc_next = vc_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SYNC_SCAN:
            begin
                if (cnt_reg == LAST_CNT)
                    state_next = ST_SYNC_DONE;
                else if (valid_reg[rd_addr] && dirty_reg[rd_addr])
                    state_next = ST_SYNC_RD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_SYNC_RD:
            begin
                state_next = ST_SYNC_WB;
            end

            ST_SYNC_WB:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    res.status   = STS_WRITEBACK;
                    res.slot     = 5'(rd_addr);
                    res.node_out = 16'(tag_q);
                    touch_en     = 1'b1;
                    touch_idx    = rd_addr;
                    dirty_next[rd_addr] = 1'b0;
                    dc_next      = dc_reg - 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    state_next   = ST_SYNC_SCAN;
                end
            end

            ST_SYNC_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.status = STS_SYNC_DONE;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // counts reported after this beat's update
        res.valid_count = 6'(vc_next);
        res.dirty_count = 6'(dc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            vc_reg        <= '0;
            dc_reg        <= '0;
            stamp_cnt_reg <= '0;
            ov_reg        <= 1'b0;
            rej_reg       <= 1'b0;
            limit_reg     <= NODE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            vc_reg    <= vc_next;
            dc_reg    <= dc_next;
            rej_reg   <= rej_next;
            if (touch_en)
                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
            if (emit)
                ov_reg <= 1'b1;
            else if (!rsp_stall)
                ov_reg <= 1'b0;
            if (psel && penable && pwrite && (paddr[2] == CFG_IDX_NODE_LIMIT))
                limit_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        id_reg          <= id_next;
        fill_ok_reg     <= fill_ok_next;
        cnt_reg         <= cnt_next;
        found_reg       <= found_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        min_idx_reg     <= min_idx_next;
        min_stamp_reg   <= min_stamp_next;
        min_tag_reg     <= min_tag_next;
        if (emit)
            rsp_reg <= res;
    end

    // tag store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[victim_idx] <= id_reg;
        tag_q <= tag_mem[rd_addr];
    end

    // stamp store, written on every touch
    always_ff @(posedge clk)
    begin
        if (touch_en)
            stamp_mem[touch_idx] <= stamp_cnt_reg + 1'b1;
        stamp_q <= stamp_mem[rd_addr];
    end

`include "lru_node_cache_tag_manager_defines.svh"

    `LNCTM_ALWAYS(a_dirty_only_occupied, (dirty_reg & ~valid_reg) == '0, "dirty empty slot")
    `LNCTM_ALWAYS(a_valid_count, vc_reg == CNT_W'($countones(valid_reg)), "valid count off")
    `LNCTM_ALWAYS(a_dirty_count, dc_reg == CNT_W'($countones(dirty_reg)), "dirty count off")
    `LNCTM_NEXT(a_take_busy, req_valid && !req_stall, state_reg != ST_IDLE, "taken but idle")

endmodule

`default_nettype wire
